// ----- design/frt_pkg.sv -----
// Shared types and codes for the fragment reassembly tracker.
package frt_pkg;

    typedef enum logic [2:0] {
        ST_COMPLETE  = 3'd0,
        ST_STORED    = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_INVALID   = 3'd3,
        ST_FULL      = 3'd4,
        ST_RESET     = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        OP_FRAGMENT = 1'b0,
        OP_RESET    = 1'b1
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic lookup;
        logic sum_pass;
        logic emit_pass;
        logic free;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_sum;
        logic pass_done;
    } dp_stat_t;

endpackage

// ----- design/fragment_reassembly_tracker_top.sv -----
// Top level of the fragment reassembly tracker.
// A request is taken when start is high and busy is low. Fragment and reset
// requests that do not complete a frame hold busy high through the lookup
// state and show their single result on the ports in the cycle after that, so
// a new request can be taken while that result is shown. A fragment that
// completes its frame keeps busy high through the lookup state, then the
// single read port of the length memory walks the run once to form the total
// size and once more to emit one result per fragment, in index order, on
// consecutive cycles (each walk issues one read per fragment, then takes in
// the last read data and closes the walk), then the free state releases the
// completed frame and the sender's older entries. Each result is shown for
// one cycle with result_valid high; the receiver cannot stall, so take every
// result as it appears. last marks the final result of each request.
module fragment_reassembly_tracker_top #(
    parameter int PENDING_ENTRIES = 8,
    parameter int MAX_FRAGMENTS   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [31:0] session,
    input  logic [63:0] frame_number,
    input  logic [7:0]  fragment_index,
    input  logic [7:0]  fragment_count,
    input  logic [15:0] payload_length,
    input  logic [15:0] frame_width,
    input  logic [15:0] frame_height,
    input  logic [7:0]  codec_code,
    input  logic        key_frame,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [31:0] out_session,
    output logic [63:0] out_frame_number,
    output logic [4:0]  out_fragment_index,
    output logic [15:0] out_fragment_length,
    output logic [20:0] total_size,
    output logic [15:0] out_width,
    output logic [15:0] out_height,
    output logic [7:0]  out_codec,
    output logic        out_key_frame,
    output logic        last
);
    import frt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequence each request through lookup, sum, emit and release
    frt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // hold the entry table and drive the result registers
    frt_datapath #(
        .PENDING_ENTRIES (PENDING_ENTRIES),
        .MAX_FRAGMENTS   (MAX_FRAGMENTS)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .opcode              (opcode),
        .session             (session),
        .frame_number        (frame_number),
        .fragment_index      (fragment_index),
        .fragment_count      (fragment_count),
        .payload_length      (payload_length),
        .frame_width         (frame_width),
        .frame_height        (frame_height),
        .codec_code          (codec_code),
        .key_frame           (key_frame),
        .result_valid        (result_valid),
        .status              (status),
        .out_session         (out_session),
        .out_frame_number    (out_frame_number),
        .out_fragment_index  (out_fragment_index),
        .out_fragment_length (out_fragment_length),
        .total_size          (total_size),
        .out_width           (out_width),
        .out_height          (out_height),
        .out_codec           (out_codec),
        .out_key_frame       (out_key_frame),
        .last                (last)
    );
endmodule

// ----- design/frt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module frt_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [2**ADDR_W];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/frt_ctrl.sv -----
// Sequencer for request lookup, summing pass, emit pass and entry release.
module frt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  frt_pkg::dp_stat_t stat,
    output frt_pkg::ctrl_cmd_t cmd
);
    import frt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_LOOKUP = 5'b00010,
        S_SUM    = 5'b00100,
        S_EMIT   = 5'b01000,
        S_FREE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = stat.need_sum ? S_SUM : S_IDLE;
            end
            S_SUM:
            begin
                cmd.sum_pass = 1'b1;
                if (stat.pass_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_pass = 1'b1;
                if (stat.pass_done)
                begin
                    state_next = S_FREE;
                end
            end
            S_FREE:
            begin
                cmd.free   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// ----- design/frt_datapath.sv -----
// Entry table, length memory walker and result registers.
module frt_datapath #(
    parameter int PENDING_ENTRIES = 8,
    parameter int MAX_FRAGMENTS   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  frt_pkg::ctrl_cmd_t cmd,
    output frt_pkg::dp_stat_t  stat,
    input  logic               opcode,
    input  logic [31:0]        session,
    input  logic [63:0]        frame_number,
    input  logic [7:0]         fragment_index,
    input  logic [7:0]         fragment_count,
    input  logic [15:0]        payload_length,
    input  logic [15:0]        frame_width,
    input  logic [15:0]        frame_height,
    input  logic [7:0]         codec_code,
    input  logic               key_frame,
    output logic               result_valid,
    output logic [2:0]         status,
    output logic [31:0]        out_session,
    output logic [63:0]        out_frame_number,
    output logic [4:0]         out_fragment_index,
    output logic [15:0]        out_fragment_length,
    output logic [20:0]        total_size,
    output logic [15:0]        out_width,
    output logic [15:0]        out_height,
    output logic [7:0]         out_codec,
    output logic               out_key_frame,
    output logic               last
);
    import frt_pkg::*;

    localparam int RUN_CAP = (MAX_FRAGMENTS < 32) ? MAX_FRAGMENTS : 32;
    localparam int SW      = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
    localparam int AW      = SW + 5;

    // captured request
    logic        op_reg;
    logic [31:0] sess_reg;
    logic [63:0] frame_reg;
    logic [7:0]  idx_reg;
    logic [7:0]  cnt_reg;
    logic [15:0] plen_reg;
    logic [15:0] w_reg;
    logic [15:0] h_reg;
    logic [7:0]  codec_reg;
    logic        key_reg;

    // entry table
    logic        ev_reg   [PENDING_ENTRIES];
    logic [31:0] em_reg   [PENDING_ENTRIES];
    logic [31:0] es_reg   [PENDING_ENTRIES];
    logic [63:0] ef_reg   [PENDING_ENTRIES];
    logic [5:0]  ec_reg   [PENDING_ENTRIES];
    logic [15:0] ew_reg   [PENDING_ENTRIES];
    logic [15:0] eh_reg   [PENDING_ENTRIES];
    logic [7:0]  ecod_reg [PENDING_ENTRIES];
    logic        ekey_reg [PENDING_ENTRIES];

    // run walker
    logic [SW-1:0] slot_reg;
    logic [5:0]    rcnt_reg;
    logic [5:0]    rk_reg;
    logic          rdv_reg;
    logic [4:0]    ridx_reg;
    logic [20:0]   total_reg;

    // result registers
    logic        rv_reg;
    status_t     status_reg;
    logic [31:0] osess_reg;
    logic [63:0] oframe_reg;
    logic [4:0]  oidx_reg;
    logic [15:0] olen_reg;
    logic [20:0] ototal_reg;
    logic [15:0] ow_reg;
    logic [15:0] oh_reg;
    logic [7:0]  ocodec_reg;
    logic        okey_reg;
    logic        olast_reg;

    logic          hit;
    logic          free_found;
    logic [SW-1:0] hit_slot;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] sel_slot;
    logic          bad;
    logic          over;
    logic          accept_ok;
    logic          dup;
    logic          complete;
    logic [31:0]   cur_mask;
    logic [31:0]   new_mask;
    logic [31:0]   bit_mask;
    logic [5:0]    cur_count;
    status_t       lk_status;
    logic          rd_en;
    logic          pass_done;
    logic [15:0]   rdata;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            sess_reg  <= session;
            frame_reg <= frame_number;
            idx_reg   <= fragment_index;
            cnt_reg   <= fragment_count;
            plen_reg  <= payload_length;
            w_reg     <= frame_width;
            h_reg     <= frame_height;
            codec_reg <= codec_code;
            key_reg   <= key_frame;
        end
    end

    // first matching entry and first free entry
    always_comb
    begin
        hit        = 1'b0;
        free_found = 1'b0;
        hit_slot   = '0;
        free_slot  = '0;
        for (int e = 0; e < PENDING_ENTRIES; e++)
        begin
            if (ev_reg[e])
            begin
                if (!hit && es_reg[e] == sess_reg && ef_reg[e] == frame_reg)
                begin
                    hit      = 1'b1;
                    hit_slot = SW'(e);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_slot  = SW'(e);
            end
        end
    end

    always_comb
    begin
        sel_slot  = hit ? hit_slot : free_slot;
        bad       = (cnt_reg == 8'd0) || (cnt_reg > 8'(RUN_CAP)) || (idx_reg >= cnt_reg);
        over      = hit && (idx_reg >= {2'b00, ec_reg[hit_slot]});
        accept_ok = (op_reg == OP_FRAGMENT) && !bad && !over && (hit || free_found);
        cur_mask  = hit ? em_reg[hit_slot] : 32'd0;
        cur_count = hit ? ec_reg[hit_slot] : cnt_reg[5:0];
        bit_mask  = 32'd1 << idx_reg[4:0];
        new_mask  = cur_mask | bit_mask;
        dup       = (plen_reg == 16'd0) || ((cur_mask & bit_mask) != 32'd0);
        complete  = (new_mask == (32'hFFFF_FFFF >> (6'd32 - cur_count)));

        priority if (op_reg == OP_RESET)
            lk_status = ST_RESET;
        else if (bad || over)
            lk_status = ST_INVALID;
        else if (!hit && !free_found)
            lk_status = ST_FULL;
        else if (dup)
            lk_status = ST_DUPLICATE;
        else if (!complete)
            lk_status = ST_STORED;
        else
            lk_status = ST_COMPLETE;
    end

    assign stat.need_sum = accept_ok && !dup && complete;

    // valid bits and received masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < PENDING_ENTRIES; e++)
            begin
                ev_reg[e] <= 1'b0;
                em_reg[e] <= 32'd0;
            end
        end
        else
        begin
            if (cmd.lookup && op_reg == OP_RESET)
            begin
                for (int e = 0; e < PENDING_ENTRIES; e++)
                begin
                    if (ev_reg[e] && es_reg[e] == sess_reg)
                    begin
                        ev_reg[e] <= 1'b0;
                    end
                end
            end
            else if (cmd.lookup && accept_ok)
            begin
                ev_reg[sel_slot] <= 1'b1;
                em_reg[sel_slot] <= dup ? cur_mask : new_mask;
            end
            if (cmd.free)
            begin
                for (int e = 0; e < PENDING_ENTRIES; e++)
                begin
                    if (ev_reg[e] && es_reg[e] == sess_reg && ef_reg[e] <= frame_reg)
                    begin
                        ev_reg[e] <= 1'b0;
                    end
                end
            end
        end
    end

    // entry metadata
    always_ff @(posedge clk)
    begin
        if (cmd.lookup && accept_ok)
        begin
            if (!hit)
            begin
                es_reg[sel_slot]   <= sess_reg;
                ef_reg[sel_slot]   <= frame_reg;
                ec_reg[sel_slot]   <= cnt_reg[5:0];
                ew_reg[sel_slot]   <= w_reg;
                eh_reg[sel_slot]   <= h_reg;
                ecod_reg[sel_slot] <= codec_reg;
            end
            ekey_reg[sel_slot] <= (hit ? ekey_reg[sel_slot] : 1'b0) | key_reg;
        end
        if (cmd.lookup)
        begin
            slot_reg <= sel_slot;
            rcnt_reg <= cur_count;
        end
    end

    assign rd_en     = (cmd.sum_pass || cmd.emit_pass) && (rk_reg < rcnt_reg);
    assign pass_done = !rd_en && !rdv_reg;
    assign stat.pass_done = pass_done;

    frt_ram #(
        .WIDTH  (16),
        .ADDR_W (AW)
    ) u_lengths (
        .clk   (clk),
        .we    (cmd.lookup && accept_ok && !dup),
        .waddr ({sel_slot, idx_reg[4:0]}),
        .wdata (plen_reg),
        .re    (rd_en),
        .raddr ({slot_reg, rk_reg[4:0]}),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_reg  <= 6'd0;
            rdv_reg <= 1'b0;
        end
        else if (cmd.lookup)
        begin
            rk_reg  <= 6'd0;
            rdv_reg <= 1'b0;
        end
        else if (cmd.sum_pass || cmd.emit_pass)
        begin
            if (pass_done)
            begin
                rk_reg <= 6'd0;
            end
            else if (rd_en)
            begin
                rk_reg <= rk_reg + 6'd1;
            end
            rdv_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= rk_reg[4:0];
        if (cmd.lookup)
        begin
            total_reg <= 21'd0;
        end
        else if (cmd.sum_pass && rdv_reg)
        begin
            total_reg <= total_reg + 21'(rdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg <= 1'b0;
        end
        else
        begin
            rv_reg <= (cmd.lookup && !stat.need_sum) || (cmd.emit_pass && rdv_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lookup && !stat.need_sum)
        begin
            status_reg <= lk_status;
            osess_reg  <= sess_reg;
            oframe_reg <= (op_reg == OP_RESET) ? 64'd0 : frame_reg;
            oidx_reg   <= 5'd0;
            olen_reg   <= 16'd0;
            ototal_reg <= 21'd0;
            ow_reg     <= 16'd0;
            oh_reg     <= 16'd0;
            ocodec_reg <= 8'd0;
            okey_reg   <= 1'b0;
            olast_reg  <= 1'b1;
        end
        else if (cmd.emit_pass && rdv_reg)
        begin
            status_reg <= ST_COMPLETE;
            osess_reg  <= sess_reg;
            oframe_reg <= frame_reg;
            oidx_reg   <= ridx_reg;
            olen_reg   <= rdata;
            ototal_reg <= total_reg;
            ow_reg     <= ew_reg[slot_reg];
            oh_reg     <= eh_reg[slot_reg];
            ocodec_reg <= ecod_reg[slot_reg];
            okey_reg   <= ekey_reg[slot_reg];
            olast_reg  <= (({1'b0, ridx_reg} + 6'd1) == rcnt_reg);
        end
    end

    assign result_valid        = rv_reg;
    assign status              = status_reg;
    assign out_session         = osess_reg;
    assign out_frame_number    = oframe_reg;
    assign out_fragment_index  = oidx_reg;
    assign out_fragment_length = olen_reg;
    assign total_size          = ototal_reg;
    assign out_width           = ow_reg;
    assign out_height          = oh_reg;
    assign out_codec           = ocodec_reg;
    assign out_key_frame       = okey_reg;
    assign last                = olast_reg;
endmodule

// ----- design/frt_checker.sv -----
// Port-level checks for the fragment reassembly tracker, bound to the top.
module frt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic [4:0]  out_fragment_index,
    input logic        last
);
    import frt_pkg::*;

    // a taken request keeps the block busy for the next cycle
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a request");

    // only a completed frame gives more than one result
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_COMPLETE |-> last)
        else $error("non-complete result without last");

    // a run of fragment results is emitted on back-to-back cycles
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid &&
        out_fragment_index == $past(out_fragment_index) + 5'd1)
        else $error("fragment run broken");

    // the final result of a request is never followed at once by another
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result directly after last");
endmodule

bind fragment_reassembly_tracker_top frt_checker u_frt_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .result_valid       (result_valid),
    .status             (status),
    .out_fragment_index (out_fragment_index),
    .last               (last)
);

// ----- test/tb_fragment_reassembly_tracker_top.sv -----
// Testbench for the fragment reassembly tracker: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module tb_fragment_reassembly_tracker_top;
    import frt_pkg::*;

    localparam int SLOTS     = 8;
    localparam int MAX_FRAGS = 32;

    // One result as the block shows it.
    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sess;
        logic [63:0] frame;
        logic [4:0]  idx;
        logic [15:0] len;
        logic [20:0] total;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  codec;
        logic        key;
        logic        last;
    } frag_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] session;
    logic [63:0] frame_number;
    logic [7:0]  fragment_index;
    logic [7:0]  fragment_count;
    logic [15:0] payload_length;
    logic [15:0] frame_width;
    logic [15:0] frame_height;
    logic [7:0]  codec_code;
    logic        key_frame;
    logic        result_valid;
    logic [2:0]  status;
    logic [31:0] out_session;
    logic [63:0] out_frame_number;
    logic [4:0]  out_fragment_index;
    logic [15:0] out_fragment_length;
    logic [20:0] total_size;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [7:0]  out_codec;
    logic        out_key_frame;
    logic        last;

    fragment_reassembly_tracker_top #(
        .PENDING_ENTRIES(SLOTS),
        .MAX_FRAGMENTS  (MAX_FRAGS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .opcode             (opcode),
        .session            (session),
        .frame_number       (frame_number),
        .fragment_index     (fragment_index),
        .fragment_count     (fragment_count),
        .payload_length     (payload_length),
        .frame_width        (frame_width),
        .frame_height       (frame_height),
        .codec_code         (codec_code),
        .key_frame          (key_frame),
        .result_valid       (result_valid),
        .status             (status),
        .out_session        (out_session),
        .out_frame_number   (out_frame_number),
        .out_fragment_index (out_fragment_index),
        .out_fragment_length(out_fragment_length),
        .total_size         (total_size),
        .out_width          (out_width),
        .out_height         (out_height),
        .out_codec          (out_codec),
        .out_key_frame      (out_key_frame),
        .last               (last)
    );

    // Predictor copy of the pending-frame table.
    logic        tbl_valid  [SLOTS];
    logic [31:0] tbl_sess   [SLOTS];
    logic [63:0] tbl_frame  [SLOTS];
    int unsigned tbl_count  [SLOTS];
    logic [31:0] tbl_mask   [SLOTS];
    logic [15:0] tbl_len    [SLOTS][32];
    logic [15:0] tbl_width  [SLOTS];
    logic [15:0] tbl_height [SLOTS];
    logic [7:0]  tbl_codec  [SLOTS];
    logic        tbl_key    [SLOTS];

    frag_result_t pending_results[$];
    int           fail_count = 0;

    // Sessions in flight, reused so random requests hit the table.
    logic [31:0] live_sess [4];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run well beyond the slowest legal sequence.
    initial
    begin
        #20ms;
        $display("tb_fragment_reassembly_tracker_top failed");
        $finish;
    end

    function automatic frag_result_t short_result(status_t st, logic [31:0] s,
                                                 logic [63:0] f);
        frag_result_t r;
        r        = '0;
        r.status = st;
        r.sess   = s;
        r.frame  = f;
        r.last   = 1'b1;
        return r;
    endfunction

    // Work out the results of one request and advance the table.
    task automatic predict_request(opcode_t op, logic [31:0] s, logic [63:0] f,
                                   logic [7:0] idx, logic [7:0] cnt,
                                   logic [15:0] plen, logic [15:0] w,
                                   logic [15:0] h, logic [7:0] cd, logic key);
        int          slot;
        int          free_slot;
        int unsigned n;
        logic [31:0] full;
        logic [20:0] sum;
        frag_result_t r;
        slot      = -1;
        free_slot = -1;
        if (op == OP_RESET)
        begin
            for (int e = 0; e < SLOTS; e++)
                if (tbl_valid[e] && tbl_sess[e] == s)
                begin
                    tbl_valid[e] = 1'b0;
                    tbl_mask[e]  = '0;
                end
            pending_results.push_back(short_result(ST_RESET, s, 64'd0));
            return;
        end
        if (cnt == 0 || cnt > MAX_FRAGS || idx >= cnt)
        begin
            pending_results.push_back(short_result(ST_INVALID, s, f));
            return;
        end
        for (int e = 0; e < SLOTS; e++)
        begin
            if (tbl_valid[e])
            begin
                if (slot < 0 && tbl_sess[e] == s && tbl_frame[e] == f)
                    slot = e;
            end
            else if (free_slot < 0)
                free_slot = e;
        end
        if (slot >= 0)
        begin
            if (idx >= tbl_count[slot])
            begin
                pending_results.push_back(short_result(ST_INVALID, s, f));
                return;
            end
        end
        else
        begin
            if (free_slot < 0)
            begin
                pending_results.push_back(short_result(ST_FULL, s, f));
                return;
            end
            slot              = free_slot;
            tbl_valid[slot]   = 1'b1;
            tbl_sess[slot]    = s;
            tbl_frame[slot]   = f;
            tbl_count[slot]   = cnt;
            tbl_mask[slot]    = '0;
            tbl_width[slot]   = w;
            tbl_height[slot]  = h;
            tbl_codec[slot]   = cd;
            tbl_key[slot]     = 1'b0;
        end
        tbl_key[slot] = tbl_key[slot] | key;
        if (plen == 0 || tbl_mask[slot][idx])
        begin
            pending_results.push_back(short_result(ST_DUPLICATE, s, f));
            return;
        end
        tbl_len[slot][idx]  = plen;
        tbl_mask[slot][idx] = 1'b1;
        n    = tbl_count[slot];
        full = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        if (tbl_mask[slot] != full)
        begin
            pending_results.push_back(short_result(ST_STORED, s, f));
            return;
        end
        sum = '0;
        for (int k = 0; k < n; k++)
            sum += tbl_len[slot][k];
        for (int k = 0; k < n; k++)
        begin
            r        = '0;
            r.status = ST_COMPLETE;
            r.sess   = s;
            r.frame  = f;
            r.idx    = k[4:0];
            r.len    = tbl_len[slot][k];
            r.total  = sum;
            r.width  = tbl_width[slot];
            r.height = tbl_height[slot];
            r.codec  = tbl_codec[slot];
            r.key    = tbl_key[slot];
            r.last   = (k + 1 == n);
            pending_results.push_back(r);
        end
        // Drop the sender's older frames along with the completed one.
        for (int e = 0; e < SLOTS; e++)
            if (tbl_valid[e] && tbl_sess[e] == s && tbl_frame[e] <= f)
            begin
                tbl_valid[e] = 1'b0;
                tbl_mask[e]  = '0;
            end
    endtask

    // Random idle cycles before a request: mostly short, now and then long.
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 2) == 0)
            return;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
    endtask

    // Send one request, hold it until taken, then predict it.
    task automatic send_request(opcode_t op, logic [31:0] s, logic [63:0] f,
                                logic [7:0] idx, logic [7:0] cnt,
                                logic [15:0] plen, logic [15:0] w,
                                logic [15:0] h, logic [7:0] cd, logic key,
                                bit gaps = 1'b1);
        if (gaps)
            idle_gap();
        start          <= 1'b1;
        opcode         <= op;
        session        <= s;
        frame_number   <= f;
        fragment_index <= idx;
        fragment_count <= cnt;
        payload_length <= plen;
        frame_width    <= w;
        frame_height   <= h;
        codec_code     <= cd;
        key_frame      <= key;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, s, f, idx, cnt, plen, w, h, cd, key);
        start <= 1'b0;
        // The block is busy in the cycle after a request is taken.
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Check each result against the oldest expectation.
    always @(posedge clk)
    begin
        frag_result_t exp_r;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result, status %0d", status);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, status);
                    fail_count++;
                end
                if (out_session !== exp_r.sess)
                begin
                    $error("out_session exp %h got %h", exp_r.sess, out_session);
                    fail_count++;
                end
                if (out_frame_number !== exp_r.frame)
                begin
                    $error("out_frame_number exp %h got %h", exp_r.frame, out_frame_number);
                    fail_count++;
                end
                if (out_fragment_index !== exp_r.idx)
                begin
                    $error("out_fragment_index exp %0d got %0d", exp_r.idx,
                           out_fragment_index);
                    fail_count++;
                end
                if (out_fragment_length !== exp_r.len)
                begin
                    $error("out_fragment_length exp %0d got %0d", exp_r.len,
                           out_fragment_length);
                    fail_count++;
                end
                if (total_size !== exp_r.total)
                begin
                    $error("total_size exp %0d got %0d", exp_r.total, total_size);
                    fail_count++;
                end
                if (out_width !== exp_r.width)
                begin
                    $error("out_width exp %0d got %0d", exp_r.width, out_width);
                    fail_count++;
                end
                if (out_height !== exp_r.height)
                begin
                    $error("out_height exp %0d got %0d", exp_r.height, out_height);
                    fail_count++;
                end
                if (out_codec !== exp_r.codec)
                begin
                    $error("out_codec exp %0d got %0d", exp_r.codec, out_codec);
                    fail_count++;
                end
                if (out_key_frame !== exp_r.key)
                begin
                    $error("out_key_frame exp %0d got %0d", exp_r.key, out_key_frame);
                    fail_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, last);
                    fail_count++;
                end
            end
        end
    end

    // Directed: field extremes, both opcodes, every status.
    task automatic test_directed();
        // Single-fragment frame with maximal fields completes at once.
        send_request(OP_FRAGMENT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 8'd1,
                     16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        // Invalid: zero count, count over the limit, index at the count, index 255.
        send_request(OP_FRAGMENT, 32'd1, 64'd0, 8'd0, 8'd0, 16'd5, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd1, 64'd0, 8'd0, 8'd33, 16'd5, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd1, 64'd0, 8'd4, 8'd4, 16'd5, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd1, 64'd0, 8'd255, 8'd255, 16'd5, 16'd1, 16'd1, 8'd1,
                     1'b0);
        // Open frame of 3, then an index beyond the stored count.
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd1, 8'd3, 16'd100, 16'd640, 16'd480,
                     8'd9, 1'b0);
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd4, 8'd8, 16'd100, 16'd1, 16'd1, 8'd1, 1'b0);
        // Empty length and duplicate index; keyframe mark still ORs in.
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd0, 8'd3, 16'd0, 16'd1, 16'd1, 8'd1, 1'b1);
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd1, 8'd3, 16'd50, 16'd1, 16'd1, 8'd1, 1'b0);
        // An older frame of the same sender, released by the later completion.
        send_request(OP_FRAGMENT, 32'd2, 64'd3, 8'd0, 8'd2, 16'd10, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd0, 8'd3, 16'd200, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd2, 64'd7, 8'd2, 8'd3, 16'd300, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd2, 64'd3, 8'd1, 8'd2, 16'd10, 16'd1, 16'd1, 8'd1, 1'b0);
        // Fill the table, overflow it, then reset the sender.
        for (int i = 0; i < SLOTS; i++)
            send_request(OP_FRAGMENT, 32'd5, 64'(i), 8'd0, 8'd2, 16'd1, 16'd1, 16'd1,
                         8'd1, 1'b0);
        send_request(OP_FRAGMENT, 32'd6, 64'd0, 8'd0, 8'd2, 16'd1, 16'd1, 16'd1, 8'd1, 1'b0);
        send_request(OP_RESET, 32'd5, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    endtask

    // Full 32-fragment frame with the largest lengths, sent back to back.
    task automatic test_widest_frame();
        for (int k = 31; k >= 0; k--)
            send_request(OP_FRAGMENT, 32'hA5A5_5A5A, 64'h8000_0000_0000_0000, 8'(k),
                         8'd32, 16'hFFFF, 16'h8000, 16'h0001, 8'h80, k == 3, 1'b0);
        // Hold off until the emitted run has drained.
        wait_drained();
    endtask

    // Random frames: mostly whole frames in shuffled order, some noise.
    task automatic test_random_frames();
        int          sent;
        int unsigned n;
        int          order[$];
        int          sel;
        logic [31:0] s;
        logic [63:0] f;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  cd;
        sent = 0;
        for (int i = 0; i < 4; i++)
            live_sess[i] = $urandom();
        while (sent < 325)
        begin
            sel = $urandom_range(0, 9);
            s   = live_sess[$urandom_range(0, 3)];
            f   = {$urandom(), $urandom()};
            if ($urandom_range(0, 1))
                f = 64'($urandom_range(0, 20));
            if (sel < 7)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 6);
                w  = 16'($urandom());
                h  = 16'($urandom());
                cd = 8'($urandom());
                order.delete();
                for (int k = 0; k < n; k++)
                    order.push_back(k);
                order.shuffle();
                // Occasionally drop a fragment so frames linger in the table.
                if ($urandom_range(0, 5) == 0 && n > 1)
                    void'(order.pop_back());
                if ($urandom_range(0, 4) == 0)
                    order.push_back(int'($urandom_range(0, n - 1)));
                foreach (order[j])
                begin
                    send_request(OP_FRAGMENT, s, f, 8'(order[j]), 8'(n),
                                 ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom()),
                                 w, h, cd, $urandom_range(0, 7) == 0);
                    sent++;
                end
            end
            else if (sel < 9)
            begin
                send_request(OP_FRAGMENT, $urandom_range(0, 1) ? s : $urandom(), f,
                             8'($urandom()), 8'($urandom()), 16'($urandom()),
                             16'($urandom()), 16'($urandom()), 8'($urandom()),
                             1'($urandom()));
                sent++;
            end
            else
            begin
                send_request(OP_RESET, s, {$urandom(), $urandom()}, 8'($urandom()),
                             8'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), 8'($urandom()), 1'($urandom()));
                sent++;
            end
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = OP_FRAGMENT;
        session        = '0;
        frame_number   = '0;
        fragment_index = '0;
        fragment_count = '0;
        payload_length = '0;
        frame_width    = '0;
        frame_height   = '0;
        codec_code     = '0;
        key_frame      = 1'b0;
        for (int e = 0; e < SLOTS; e++)
        begin
            tbl_valid[e] = 1'b0;
            tbl_mask[e]  = '0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_widest_frame();
        test_random_frames();

        // Let the last results arrive, then allow the block to settle.
        fork
            wait_drained();
            begin
                repeat (200000) @(posedge clk);
                $error("results still outstanding: %0d", pending_results.size());
                fail_count++;
            end
        join_any
        disable fork;
        repeat (80) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb_fragment_reassembly_tracker_top passed");
        else
            $display("tb_fragment_reassembly_tracker_top failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/frt_pkg.sv
design/frt_ram.sv
design/frt_ctrl.sv
design/frt_datapath.sv
design/fragment_reassembly_tracker_top.sv
design/frt_checker.sv
test/tb_fragment_reassembly_tracker_top.sv
